[sv/chol_pkg.sv]
`timescale 1ns / 1ps
package chol_pkg;
    typedef logic signed [31:0] t_q16;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = -32'sh7FFFFFFF - 32'sd1;

    function automatic t_q16 sat32(input logic signed [63:0] v);
        if (v > 64'sh000000007FFFFFFF) return Q_MAX;
        if (v < -64'sh0000000080000000) return Q_MIN;
        return v[31:0];
    endfunction
endpackage

[sv/chol_div.sv]
`timescale 1ns / 1ps
// Restoring divider: quotient of (rem << 16) / den, truncated toward zero,
// saturated. One quotient bit per cycle, 48 bits.
module chol_div
    import chol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_q16        i_num,
    input  t_q16        i_den,
    output logic        o_done,
    output t_q16        o_quo
);
    logic [47:0] r_num;
    logic [31:0] r_den;
    logic [48:0] r_rem;
    logic [47:0] r_quo;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [48:0] n_try;
    logic [48:0] n_shift;
    logic signed [63:0] n_val;

    assign n_shift = {r_rem[47:0], r_num[47]};
    assign n_try   = n_shift - {17'd0, r_den};

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_num  <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'd0};
            r_den  <= i_den;
            r_neg  <= i_num[31];
            r_rem  <= '0;
            r_quo  <= '0;
            r_cnt  <= 6'd48;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_num <= {r_num[46:0], 1'b0};
            if (!n_try[48]) begin
                r_rem <= n_try;
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_quo <= {r_quo[46:0], 1'b0};
            end
            if (r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_comb begin
        n_val = r_neg ? -$signed({16'd0, r_quo}) : $signed({16'd0, r_quo});
        o_quo = sat32(n_val);
    end
endmodule

[sv/cholesky_decomposition_top.sv]
`timescale 1ns / 1ps
// Cholesky factorization of a symmetric Q16.16 matrix of size n (1..MAX_DIM).
// Input channel: one matrix_element per transfer, row-major, n*n transfers per
// matrix. Elements above the diagonal are counted but dropped. After the last
// element the block stops taking input (o_in_stall goes high) and computes L
// column by column out of one synchronous memory that holds A, then L in place.
// Each dot-product term steps through a loop test, two memory reads, a multiply
// and an accumulate; square roots are computed bit by bit in the controller and
// divisions in one shared iterative divider.
// Output channel: the lower triangle in row-major order, one transfer per
// entry, o_last_entry on (n-1,n-1). A non positive radicand gives one transfer
// with o_not_positive_definite and o_last_entry set, then the block returns to
// loading. A high i_out_stall simply holds the current result.
// Configuration: writing matrix_size drops any partial matrix and wins over an
// element offered in the same cycle. Sizes 0 and above MAX_DIM act as 1 and
// MAX_DIM. Reset sets the size to 8, or MAX_DIM if smaller, empties the load
// count and returns the controller to loading; memory is not cleared.
module cholesky_decomposition_top
    import chol_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_matrix_element,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_factor_value,
    output logic [2:0]  o_row_index,
    output logic [2:0]  o_col_index,
    output logic        o_not_positive_definite,
    output logic        o_last_entry,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_matrix_size
);
    localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW = 2 * IW;
    localparam int CW = $clog2(MAX_DIM * MAX_DIM + 1);

    localparam logic [3:0] S_LOAD = 4'd0, S_DIAG = 4'd1, S_RD1 = 4'd2,
        S_RD2 = 4'd3, S_MUL = 4'd4, S_ACC = 4'd5, S_RDA = 4'd6, S_SUB = 4'd7,
        S_SQRT = 4'd8, S_DIV = 4'd9, S_WR = 4'd10, S_ORD = 4'd11,
        S_OUT = 4'd12, S_ERR = 4'd13;

    logic [31:0] r_mem [MAX_DIM * MAX_DIM];
    logic [31:0] r_rd;
    logic [AW-1:0] n_ra;
    logic        n_we;
    logic [AW-1:0] n_wa;
    logic [31:0] n_wd;

    logic [3:0]  r_size;
    logic [3:0]  n_n;
    logic [CW-1:0] r_cnt;
    logic [IW:0] r_lr, r_lc;
    logic [3:0]  r_st;
    logic [IW-1:0] r_m, r_r, r_k;
    t_q16        r_a, r_acc, r_diag;
    t_q16        n_rem;
    logic signed [63:0] r_prod;
    t_q16        r_val;
    logic        r_err, r_last;
    logic [IW-1:0] r_orow, r_ocol;

    logic [63:0] r_sx, r_sres, r_sbit;
    logic        div_start, div_done;
    t_q16        div_quo;

    always_comb begin
        if (i_cfg_matrix_size == 4'd0) n_n = 4'd1;
        else if ({28'd0, i_cfg_matrix_size} > 32'(MAX_DIM)) n_n = 4'(MAX_DIM);
        else n_n = i_cfg_matrix_size;
    end

    function automatic logic [AW-1:0] addr(input logic [IW-1:0] a,
                                           input logic [IW-1:0] b);
        return AW'(32'(a) * MAX_DIM + 32'(b));
    endfunction

    // A configuration write takes the cycle, so an element waits behind it.
    assign o_in_stall  = (r_st != S_LOAD) || i_cfg_valid;
    assign o_cfg_ready = (r_st == S_LOAD);

    // Remainder of the entry being worked on: stored value minus the dot product.
    assign n_rem = sat32(64'($signed(r_rd)) - 64'(r_acc));

    chol_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(n_rem), .i_den(r_diag), .o_done(div_done), .o_quo(div_quo)
    );
    assign div_start = (r_st == S_SUB) && (r_r != r_m);

    // Memory read address and write port.
    always_comb begin
        n_ra = addr(r_r, r_k);
        unique case (r_st)
            S_RD1:   n_ra = addr(r_r, r_k);
            S_RD2:   n_ra = addr(r_m, r_k);
            S_RDA:   n_ra = addr(r_r, r_m);
            S_ORD:   n_ra = addr(r_r, r_k);
            default: n_ra = addr(r_r, r_k);
        endcase
        n_we = 1'b0;
        n_wa = addr(r_r, r_m);
        n_wd = r_val;
        if (r_st == S_LOAD && i_in_valid && !i_cfg_valid && r_lc <= r_lr) begin
            n_we = 1'b1;
            n_wa = addr(r_lr[IW-1:0], r_lc[IW-1:0]);
            n_wd = i_matrix_element;
        end else if (r_st == S_WR) begin
            n_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_wa] <= n_wd;
        r_rd <= r_mem[n_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= 4'd8 > 4'(MAX_DIM) ? 4'(MAX_DIM) : 4'd8;
            r_cnt       <= '0;
            r_lr        <= '0;
            r_lc        <= '0;
            r_st        <= S_LOAD;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_st)
                S_LOAD: begin
                    if (i_cfg_valid) begin
                        r_size <= n_n;
                        r_cnt  <= '0;
                        r_lr   <= '0;
                        r_lc   <= '0;
                    end else if (i_in_valid) begin
                        if (32'(r_cnt) + 1 == 32'(r_size) * 32'(r_size)) begin
                            r_cnt <= '0;
                            r_lr  <= '0;
                            r_lc  <= '0;
                            r_m   <= '0;
                            r_r   <= '0;
                            r_k   <= '0;
                            r_acc <= '0;
                            r_st  <= S_DIAG;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                            if (32'(r_lc) + 1 == 32'(r_size)) begin
                                r_lc <= '0;
                                r_lr <= r_lr + 1'b1;
                            end else begin
                                r_lc <= r_lc + 1'b1;
                            end
                        end
                    end
                end
                S_DIAG: r_st <= (r_k == r_m) ? S_RDA : S_RD1;
                S_RD1:  r_st <= S_RD2;
                S_RD2: begin
                    r_a  <= r_rd;
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= $signed(r_a) * $signed(r_rd);
                    r_st   <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= sat32(64'(r_acc) + 64'(sat32(r_prod >>> 16)));
                    r_k   <= r_k + 1'b1;
                    r_st  <= S_DIAG;
                end
                S_RDA: r_st <= S_SUB;
                S_SUB: begin
                    if (r_r == r_m) begin
                        if (n_rem <= 0) begin
                            r_val  <= '0;
                            r_err  <= 1'b1;
                            r_last <= 1'b1;
                            r_orow <= r_m;
                            r_ocol <= r_m;
                            o_out_valid <= 1'b1;
                            r_st   <= S_ERR;
                        end else begin
                            r_sx  <= {32'd0, n_rem} << 16;
                            r_sres <= '0;
                            r_sbit <= 64'd1 << 62;
                            r_st  <= S_SQRT;
                        end
                    end else begin
                        r_st <= S_DIV;
                    end
                end
                S_SQRT: begin
                    if (r_sbit == 64'd0) begin
                        r_val  <= r_sres[31:0];
                        r_diag <= r_sres[31:0];
                        r_st   <= S_WR;
                    end else begin
                        if (r_sx >= r_sres + r_sbit) begin
                            r_sx   <= r_sx - (r_sres + r_sbit);
                            r_sres <= (r_sres >> 1) + r_sbit;
                        end else begin
                            r_sres <= r_sres >> 1;
                        end
                        r_sbit <= r_sbit >> 2;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_val <= div_quo;
                        r_st  <= S_WR;
                    end
                end
                S_WR: begin
                    r_k   <= '0;
                    r_acc <= '0;
                    if (32'(r_r) + 1 < 32'(r_size)) begin
                        r_r  <= r_r + 1'b1;
                        r_st <= S_DIAG;
                    end else if (32'(r_m) + 1 < 32'(r_size)) begin
                        r_m  <= r_m + 1'b1;
                        r_r  <= r_m + 1'b1;
                        r_st <= S_DIAG;
                    end else begin
                        r_r  <= '0;
                        r_st <= S_ORD;
                    end
                end
                S_ORD: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    // r_rd now holds L[r][k]; present it, then step.
                    if (!o_out_valid) begin
                        r_val  <= r_rd;
                        r_err  <= 1'b0;
                        r_orow <= r_r;
                        r_ocol <= r_k;
                        r_last <= (32'(r_r) + 1 == 32'(r_size)) && (r_k == r_r);
                        o_out_valid <= 1'b1;
                    end else if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        if (r_last) begin
                            r_st <= S_LOAD;
                        end else begin
                            if (r_k == r_r) begin
                                r_k <= '0;
                                r_r <= r_r + 1'b1;
                            end else begin
                                r_k <= r_k + 1'b1;
                            end
                            r_st <= S_ORD;
                        end
                    end
                end
                S_ERR: begin
                    if (!i_out_stall) begin
                        o_out_valid <= 1'b0;
                        r_st <= S_LOAD;
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    assign o_factor_value          = r_val;
    assign o_row_index             = 3'(r_orow);
    assign o_col_index             = 3'(r_ocol);
    assign o_not_positive_definite = r_err;
    assign o_last_entry            = r_last;
endmodule

[sv/chol_checker.sv]
`timescale 1ns / 1ps
module chol_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_row_index,
    input logic [2:0] o_col_index,
    input logic       o_not_positive_definite,
    input logic       o_last_entry,
    input logic       o_in_stall
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_row_index))
        else $error("stalled result dropped");
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_col_index <= o_row_index)
        else $error("column above row");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_not_positive_definite |-> o_last_entry)
        else $error("error result not last");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while emitting");
endmodule

bind cholesky_decomposition_top chol_checker u_chk (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
    import chol_pkg::*;

    // Clock, reset and the ports of the block.
    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_matrix_element;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_factor_value;
    logic [2:0]  o_row_index;
    logic [2:0]  o_col_index;
    logic        o_not_positive_definite;
    logic        o_last_entry;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_matrix_size;

    cholesky_decomposition_top #(.MAX_DIM(8)) u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_matrix_element       (i_matrix_element),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_factor_value         (o_factor_value),
        .o_row_index            (o_row_index),
        .o_col_index            (o_col_index),
        .o_not_positive_definite(o_not_positive_definite),
        .o_last_entry           (o_last_entry),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_matrix_size      (i_cfg_matrix_size)
    );

    // One entry of the factor as it leaves the block.
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        npd;
        logic        last;
    } t_factor_entry;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 4000;

    // Shadow of the block's state used by the predictor.
    logic signed [31:0] shadow_store [64];
    logic signed [31:0] shadow_factor [64];
    int unsigned        shadow_count;
    logic [3:0]         shadow_size;

    logic [31:0]   element_queue [$];
    t_factor_entry expected_entries [$];

    int  mismatch_count;
    int  elements_sent;
    int  entries_seen;
    int  error_entries_seen;
    int  matrices_seen;
    int  idle_cycles;
    int  in_gap;
    int  out_gap;
    bit  sender_hold;

    // Q16.16 helpers written in terms of 64-bit signed arithmetic.
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] q_mult(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        // The arithmetic shift rounds toward minus infinity.
        return clamp32(p >>> 16);
    endfunction

    function automatic logic [31:0] root_of(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic int unsigned size_in_use();
        if (shadow_size == 0) return 1;
        if (shadow_size > 8) return 8;
        return shadow_size;
    endfunction

    // Takes one accepted element; after the last one of a matrix the
    // factorization is computed and the expected entries are queued.
    task automatic factor_element(input logic [31:0] elem);
        int unsigned n, row, col, m, r, k;
        logic signed [31:0] sum, rad, diag, acc, rem;
        logic signed [63:0] num;
        t_factor_entry fe;
        n   = size_in_use();
        row = shadow_count / n;
        col = shadow_count % n;
        if (col <= row) shadow_store[row * 8 + col] = elem;
        shadow_count++;
        if (shadow_count < n * n) return;
        shadow_count = 0;
        for (m = 0; m < n; m++) begin
            sum = 0;
            for (k = 0; k < m; k++)
                sum = clamp32(64'(sum) + 64'(q_mult(shadow_factor[m * 8 + k],
                                                    shadow_factor[m * 8 + k])));
            rad = clamp32(64'(shadow_store[m * 8 + m]) - 64'(sum));
            if (rad <= 0) begin
                fe = '{value: 32'd0, row: m[2:0], col: m[2:0], npd: 1'b1, last: 1'b1};
                expected_entries.push_back(fe);
                return;
            end
            diag = root_of({32'd0, rad} << 16);
            shadow_factor[m * 8 + m] = diag;
            for (r = m + 1; r < n; r++) begin
                acc = 0;
                for (k = 0; k < m; k++)
                    acc = clamp32(64'(acc) + 64'(q_mult(shadow_factor[r * 8 + k],
                                                        shadow_factor[m * 8 + k])));
                rem = clamp32(64'(shadow_store[r * 8 + m]) - 64'(acc));
                num = 64'(rem) <<< 16;
                shadow_factor[r * 8 + m] = clamp32(num / 64'(diag));
            end
        end
        for (r = 0; r < n; r++)
            for (k = 0; k <= r; k++) begin
                fe = '{value: shadow_factor[r * 8 + k], row: r[2:0], col: k[2:0],
                       npd: 1'b0, last: (r == n - 1 && k == r)};
                expected_entries.push_back(fe);
            end
    endtask

    // Gap lengths: mostly none or short, now and then long.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 0;
        if (sel < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Input driver: presents the head of the element queue, and holds the
    // payload steady while the block stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid       <= 1'b0;
            i_matrix_element <= '0;
            in_gap           = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                factor_element(i_matrix_element);
                elements_sent++;
                void'(element_queue.pop_front());
                in_gap = pick_gap();
            end
            if (i_in_valid && o_in_stall) begin
                // Hold the transfer.
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (element_queue.size() != 0 && !sender_hold) begin
                i_in_valid       <= 1'b1;
                i_matrix_element <= element_queue[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks every result transfer against the oldest
    // expected entry, and stalls the result channel at random.
    always @(posedge i_clk) begin
        t_factor_entry got;
        t_factor_entry want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap     = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{value: o_factor_value, row: o_row_index, col: o_col_index,
                        npd: o_not_positive_definite, last: o_last_entry};
                entries_seen++;
                if (got.npd) error_entries_seen++;
                if (got.last) matrices_seen++;
                if (expected_entries.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transfer: value %h row %0d col %0d",
                                 got.value, got.row, got.col);
                end else begin
                    want = expected_entries.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"Mismatch: expected value %h row %0d col %0d npd %0b ",
                                      "last %0b, got value %h row %0d col %0d npd %0b last %0b"},
                                     want.value, want.row, want.col, want.npd, want.last,
                                     got.value, got.row, got.col, got.npd, got.last);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else begin
                out_gap = pick_gap();
                i_out_stall <= (out_gap > 0);
            end
        end
    end

    // Watchdog: counts cycles in which no channel moves a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                     || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired with %0d entries outstanding",
                         expected_entries.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Waits until the block has drained its results, then lets any
    // remaining computation settle before the next register write.
    task automatic wait_idle();
        while (element_queue.size() != 0 || i_in_valid || expected_entries.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [3:0] sz);
        i_cfg_valid       <= 1'b1;
        i_cfg_matrix_size <= sz;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid  <= 1'b0;
        shadow_size  = sz;
        shadow_count = 0;
    endtask

    // A random matrix. Most are symmetric and made positive definite by a dominant
    // diagonal; a share are left arbitrary to reach the error path.
    task automatic queue_matrix(input int unsigned n, input bit wellformed);
        logic signed [31:0] a [64];
        int unsigned r, c;
        for (r = 0; r < n; r++)
            for (c = 0; c <= r; c++) begin
                if (wellformed) begin
                    a[r * 8 + c] = $signed($urandom_range(0, 32'h0003FFFF)) - 32'sh20000;
                    if (r == c) a[r * 8 + c] = $urandom_range(32'h00100000, 32'h7FFFFFFF);
                end else begin
                    a[r * 8 + c] = $urandom;
                end
                a[c * 8 + r] = a[r * 8 + c];
            end
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                element_queue.push_back((c > r && !wellformed) ? $urandom : a[r * 8 + c]);
    endtask

    task automatic run_matrices(input logic [3:0] sz, input int count);
        int unsigned n;
        n = (sz == 0) ? 1 : (sz > 8 ? 8 : sz);
        repeat (count) queue_matrix(n, $urandom_range(0, 9) < 8);
    endtask

    initial begin
        int unsigned i;
        logic [3:0] sz;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_matrix_element  = '0;
        i_out_stall       = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_matrix_size = '0;
        sender_hold       = 1'b0;
        mismatch_count    = 0;
        elements_sent     = 0;
        entries_seen      = 0;
        error_entries_seen = 0;
        matrices_seen     = 0;
        shadow_count      = 0;
        shadow_size       = 4'd8;
        for (i = 0; i < 64; i++) begin
            shadow_store[i]  = 0;
            shadow_factor[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: size 1 with the field extremes, a zero and negative
        // radicand, then size zero; an oversized setting comes after size 2.
        write_size(4'd1);
        element_queue.push_back(32'h7FFFFFFF);
        element_queue.push_back(32'h80000000);
        element_queue.push_back(32'h00000000);
        element_queue.push_back(32'h00010000);
        element_queue.push_back(32'hFFFFFFFF);
        element_queue.push_back(32'h00000001);
        wait_idle();
        write_size(4'd0);
        element_queue.push_back(32'h00040000);
        wait_idle();
        // Size 2: identity, then an error on the second diagonal.
        write_size(4'd2);
        element_queue.push_back(32'h00010000);
        element_queue.push_back(32'h7FFFFFFF);
        element_queue.push_back(32'h00000000);
        element_queue.push_back(32'h00010000);
        element_queue.push_back(32'h00010000);
        element_queue.push_back(32'h00000000);
        element_queue.push_back(32'h00010000);
        element_queue.push_back(32'h00010000);
        wait_idle();
        // A write in the middle of a load drops the partial matrix.
        element_queue.push_back(32'h00050000);
        wait_idle();
        write_size(4'd15);
        run_matrices(4'd15, 1);
        wait_idle();

        // Random phases across sizes; most matrices are small.
        for (i = 0; i < 8; i++) begin
            sz = (i % 4 == 3) ? 4'd8 : 4'($urandom_range(1, 5));
            write_size(sz);
            run_matrices(sz, (sz > 5) ? 1 : $urandom_range(2, 5));
            if (i == 5) begin
                // Hold the sender until every outstanding entry has come out.
                while (element_queue.size() > 5) @(posedge i_clk);
                sender_hold = 1'b1;
                while (i_in_valid || expected_entries.size() != 0) @(posedge i_clk);
                sender_hold = 1'b0;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d elements; checked %0d factor entries over %0d matrices,",
                 elements_sent, entries_seen, matrices_seen);
        $display("%0d of them not positive definite; sizes 0, 1..5, 8 and 15 used.",
                 error_entries_seen);
        if (mismatch_count == 0 && expected_entries.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/chol_pkg.sv
sv/chol_div.sv
sv/cholesky_decomposition_top.sv
sv/chol_checker.sv
tb/tb.sv
